### hw/rtl/modular_element_alu_assert.svh
// Assertion macros for the modular element ALU.
`ifndef MODULAR_ELEMENT_ALU_ASSERT_SVH
`define MODULAR_ELEMENT_ALU_ASSERT_SVH
`ifndef SYNTH
`define MEA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("sequencer check failed");
`define MEA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("sequencer check failed");
`else
`define MEA_ASSERT_IMP(label, clk, rst, a, c)
`define MEA_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### hw/rtl/mea_pkg.sv
// ----------------------------------------------------------------------------
// mea_pkg
// Shared constants and types of the modular element ALU.
// ----------------------------------------------------------------------------
package mea_pkg;
  localparam int unsigned ELEM_WIDTH = 64;
  localparam int unsigned CFG_WIDTH = 64;

  typedef enum logic [2:0] {
    CMD_REDUCE = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUB    = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_EXP    = 3'd4,
    CMD_INV    = 3'd5,
    CMD_SWITCH = 3'd6,
    CMD_PARITY = 3'd7
  } cmd_t;

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_TARGET  = 1'b1;
endpackage

### hw/rtl/mea_mulmod.sv
// ----------------------------------------------------------------------------
// mea_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, double and add.
// ----------------------------------------------------------------------------
module mea_mulmod #(
  parameter int unsigned W = mea_pkg::ELEM_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] p
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  ysh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    dbl;
  logic [W-1:0]  dred;
  logic [W:0]    sum;
  logic [W-1:0]  acc_next;

  // Double then conditionally add, each followed by a conditional subtract of m.
  always_comb begin
    dbl  = {acc, 1'b0};
    dred = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
    sum  = {1'b0, dred} + {1'b0, x};
    if (ysh[W-1]) begin
      acc_next = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
    end else begin
      acc_next = dred;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      acc  <= '0;
      ysh  <= y;
      cnt  <= CW'(W);
    end else if (busy) begin
      acc <= acc_next;
      ysh <= {ysh[W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign p = acc;
endmodule

### hw/rtl/mea_divider.sv
// ----------------------------------------------------------------------------
// mea_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mea_divider #(
  parameter int unsigned W = mea_pkg::ELEM_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  r;
  logic [W-1:0]  q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {r, q[W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      r    <= '0;
      q    <= num;
      cnt  <= CW'(W);
    end else if (busy) begin
      // Shift in one dividend bit and try a subtract.
      if (trial >= {1'b0, den}) begin
        r <= W'(trial - {1'b0, den});
        q <= {q[W-2:0], 1'b1};
      end else begin
        r <= trial[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = q;
  assign rem = r;
endmodule

### hw/rtl/modular_element_alu.sv
// The time from accept to out_valid depends on the command and is set by the
// bit-serial divider and multiplier; for exp and inverse it also depends on the
// operands. One beat is in flight at a time; the next beat can be taken in the
// cycle after the result beat leaves. Reset: synchronous, active high; both
// moduli return to 2.
// ----------------------------------------------------------------------------
// modular_element_alu
// Sequencer around a shared serial divider and serial modular multiplier.
// ----------------------------------------------------------------------------
`include "modular_element_alu_assert.svh"
module modular_element_alu #(
  parameter int unsigned ELEM_WIDTH = mea_pkg::ELEM_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mea_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    cmd,
  input  logic [ELEM_WIDTH-1:0]         operand_a,
  input  logic [ELEM_WIDTH-1:0]         operand_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ELEM_WIDTH-1:0]         result,
  output logic                          no_inverse
);
  localparam int unsigned W = ELEM_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_REDA   = 14'b00000000000010,
    S_REDB   = 14'b00000000000100,
    S_OP     = 14'b00000000001000,
    S_EXPSQ  = 14'b00000000010000,
    S_EXPMUL = 14'b00000000100000,
    S_INVDIV = 14'b00000001000000,
    S_INVQM  = 14'b00000010000000,
    S_INVMUL = 14'b00000100000000,
    S_SWA    = 14'b00001000000000,
    S_SWD    = 14'b00010000000000,
    S_OUT    = 14'b00100000000000,
    S_WAIT   = 14'b01000000000000,
    S_INVSTP = 14'b10000000000000
  } state_t;

  state_t        state;
  logic [W-1:0]  modulus;
  logic [W-1:0]  target_modulus;
  logic [W-1:0]  m, nm;
  mea_pkg::cmd_t op;
  logic [W-1:0]  a, b, rawb, aux;
  logic [W-1:0]  r0, r1, t0, t1;
  logic [CW-1:0] ecnt;
  logic          sub_phase;

  logic          div_start, div_done, mul_start, mul_done;
  logic [W-1:0]  div_num, div_den, div_q, div_r;
  logic [W-1:0]  mul_x, mul_y, mul_p;

  // Effective moduli: 0 and 1 act as 1.
  assign m  = (modulus < W'(2)) ? W'(1) : modulus;
  assign nm = (target_modulus < W'(2)) ? W'(1) : target_modulus;

  mea_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q), .rem(div_r)
  );
  mea_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .x(mul_x), .y(mul_y), .m(m),
    .done(mul_done), .p(mul_p)
  );

  logic [W:0]   s1;
  logic [W-1:0] addv, subv, half, diff;
  assign half = m >> 1;
  assign diff = (m > nm) ? W'(m - nm) : W'(nm - m);
  // Shared modular add/sub on the current operand pair.
  always_comb begin
    s1   = {1'b0, a} + {1'b0, b};
    addv = (s1 >= {1'b0, m}) ? W'(s1 - {1'b0, m}) : s1[W-1:0];
    subv = (a >= b) ? W'(a - b) : W'(a + (m - b));
  end

  assign in_stall = (state != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus        <= W'(2);
      target_modulus <= W'(2);
    end else if (cfg_we) begin
      if (cfg_index == mea_pkg::REG_MODULUS) modulus <= cfg_data[W-1:0];
      else target_modulus <= cfg_data[W-1:0];
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    mul_start <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= mea_pkg::cmd_t'(cmd);
            rawb      <= operand_b;
            b         <= operand_b;
            div_num   <= operand_a;
            div_den   <= m;
            div_start <= 1'b1;
            no_inverse <= 1'b0;
            state     <= S_REDA;
          end
        end
        S_REDA: begin
          if (div_done) begin
            a         <= div_r;
            div_num   <= b;
            div_start <= 1'b1;
            state     <= S_REDB;
          end
        end
        S_REDB: begin
          if (div_done) begin
            b     <= div_r;
            state <= S_OP;
          end
        end
        S_OP: begin
          case (op)
            mea_pkg::CMD_REDUCE: begin result <= a; state <= S_OUT; end
            mea_pkg::CMD_ADD: begin result <= addv; state <= S_OUT; end
            mea_pkg::CMD_SUB: begin result <= subv; state <= S_OUT; end
            mea_pkg::CMD_MUL: begin
              mul_x <= a; mul_y <= b; mul_start <= 1'b1;
              ecnt <= CW'(1); sub_phase <= 1'b1;
              state <= S_EXPMUL;
            end
            mea_pkg::CMD_EXP: begin
              ecnt <= CW'(W);
              mul_x <= (m == W'(1)) ? '0 : W'(1);
              mul_y <= (m == W'(1)) ? '0 : W'(1);
              mul_start <= 1'b1;
              sub_phase <= 1'b0;
              state <= S_EXPSQ;
            end
            mea_pkg::CMD_INV: begin
              if (m == W'(1)) begin
                result <= '0; state <= S_OUT;
              end else begin
                r0 <= m; r1 <= a; t0 <= '0; t1 <= W'(1);
                state <= S_INVSTP;
              end
            end
            mea_pkg::CMD_SWITCH: begin
              div_num <= a; div_den <= nm; div_start <= 1'b1;
              state <= S_SWA;
            end
            default: begin
              result <= (a > half) ? {{(W-1){1'b0}}, ~a[0]} : {{(W-1){1'b0}}, a[0]};
              state  <= S_OUT;
            end
          endcase
        end
        // Square step of square-and-multiply, MSB first.
        S_EXPSQ: begin
          if (mul_done) begin
            if (rawb[W-1]) begin
              mul_x <= mul_p; mul_y <= a; mul_start <= 1'b1;
              state <= S_EXPMUL;
            end else if (ecnt == CW'(1)) begin
              result <= mul_p; state <= S_OUT;
            end else begin
              mul_x <= mul_p; mul_y <= mul_p; mul_start <= 1'b1;
              rawb <= {rawb[W-2:0], 1'b0}; ecnt <= ecnt - 1'b1;
            end
          end
        end
        S_EXPMUL: begin
          if (mul_done) begin
            if (sub_phase || ecnt == CW'(1)) begin
              result <= mul_p; state <= S_OUT;
            end else begin
              mul_x <= mul_p; mul_y <= mul_p; mul_start <= 1'b1;
              rawb <= {rawb[W-2:0], 1'b0}; ecnt <= ecnt - 1'b1;
              state <= S_EXPSQ;
            end
          end
        end
        // Extended Euclid: one quotient per round.
        S_INVSTP: begin
          if (r1 == '0) begin
            if (r0 != W'(1)) begin
              result <= '0; no_inverse <= 1'b1;
            end else begin
              result <= t0;
            end
            state <= S_OUT;
          end else begin
            div_num <= r0; div_den <= r1; div_start <= 1'b1;
            state <= S_INVDIV;
          end
        end
        S_INVDIV: begin
          if (div_done) begin
            aux <= div_r;
            div_num <= div_q; div_den <= m; div_start <= 1'b1;
            state <= S_INVQM;
          end
        end
        S_INVQM: begin
          if (div_done) begin
            mul_x <= t1; mul_y <= div_r; mul_start <= 1'b1;
            state <= S_INVMUL;
          end
        end
        S_INVMUL: begin
          if (mul_done) begin
            r0 <= r1; r1 <= aux;
            t0 <= t1;
            t1 <= (t0 >= mul_p) ? W'(t0 - mul_p) : W'(t0 + (m - mul_p));
            state <= S_INVSTP;
          end
        end
        S_SWA: begin
          if (div_done) begin
            aux     <= div_r;
            div_num <= diff; div_den <= nm; div_start <= 1'b1;
            state   <= S_SWD;
          end
        end
        S_SWD: begin
          if (div_done) begin
            if (a <= half) begin
              result <= aux;
            end else if (m < nm) begin
              result <= (({1'b0, aux} + {1'b0, div_r}) >= {1'b0, nm}) ?
                        W'(aux - (nm - div_r)) : W'(aux + div_r);
            end else begin
              result <= (aux >= div_r) ? W'(aux - div_r) : W'(aux + (nm - div_r));
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  `MEA_ASSERT_IMP(a_valid_only_wait, clk, rst, out_valid, state == S_WAIT)
  `MEA_ASSERT_IMP(a_flag_inv_only, clk, rst, out_valid && no_inverse,
                  op == mea_pkg::CMD_INV && result == '0)
  `MEA_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)
endmodule
